@@ rtl/vim_pkg.sv @@
// shared types, constants and register map for the velocity integration motion alarm
`default_nettype none

package vim_pkg;

  // default parameter values
  localparam int SampleWidthDef   = 13;
  localparam int VelocityWidthDef = 32;

  // fixed field widths
  localparam int DtW       = 16;
  localparam int DeadbandW = 12;
  localparam int LimitW    = 8;
  localparam int ThreshW   = 63;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 63;

  // register map
  localparam logic [CfgIdxW-1:0] RegRestX    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRestY    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRestZ    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDeadband = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLimit    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegThresh   = 3'd5;

  // register reset values
  localparam int                   RestXReset    = 0;
  localparam int                   RestYReset    = 0;
  localparam int                   RestZReset    = 256;
  localparam logic [DeadbandW-1:0] DeadbandReset = 12'd16;
  localparam logic [LimitW-1:0]    LimitReset    = 8'd25;
  localparam logic [ThreshW-1:0]   ThreshReset   = 63'd1000000;

  // axis selectors
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_ADD,
    ST_SQ,
    ST_SQ_ACC,
    ST_DONE
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic       in_ready;
    logic       eval;
    logic       mul_int;
    logic       add_int;
    logic       mul_sq;
    logic       acc_sq;
    logic       finish;
    logic [1:0] axis;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic all_still;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/vim_mul.sv @@
// shared unsigned multiplier with registered product
`default_nettype none

module vim_mul #(
  parameter int Width = 32
) (
  input  logic                 clk,
  input  logic [Width-1:0]     a,
  input  logic [Width-1:0]     b,
  output logic [2*Width-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

@@ rtl/vim_ctrl.sv @@
// sequencer stepping the shared multiplier through integration and squaring
`default_nettype none

module vim_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  vim_pkg::stat_t stat,
  output vim_pkg::ctrl_t ctrl
);

  import vim_pkg::*;

  state_t     state, state_next;
  logic [1:0] axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= AxisX;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    axis_next  = axis;
    unique case (state)
      ST_IDLE: begin
        if (stat.in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        axis_next  = AxisX;
        state_next = stat.all_still ? ST_SQ : ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        if (axis == AxisZ) begin
          axis_next  = AxisX;
          state_next = ST_SQ;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_MUL;
        end
      end
      ST_SQ: begin
        if (axis == AxisZ) begin
          state_next = ST_SQ_ACC;
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      ST_SQ_ACC: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl      = '0;
    ctrl.axis = axis;
    unique case (state)
      ST_IDLE:   ctrl.in_ready = 1'b1;
      ST_EVAL:   ctrl.eval     = 1'b1;
      ST_MUL:    ctrl.mul_int  = 1'b1;
      ST_ADD:    ctrl.add_int  = 1'b1;
      ST_SQ: begin
        ctrl.mul_sq = 1'b1;
        ctrl.acc_sq = (axis != AxisX);
      end
      ST_SQ_ACC: ctrl.acc_sq   = 1'b1;
      ST_DONE:   ctrl.finish   = stat.out_free;
      default:   ctrl.in_ready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/velocity_integration_motion_alarm.sv @@
// top level: velocity integration with rest reset and squared speed alarm
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_ready     | accel_x, accel_y, accel_z, elapsed_ms
//  out     | out_valid / out_ready   | motion_alarm, rest_reset
//  cfg     | cfg_we (no wait)        | cfg_index, cfg_data
//
//  the single shared multiplier sets the pace: a moving item takes a multiply
//  and an add step per axis to integrate, then a squaring step per axis and
//  a final add; a still item skips the integration steps.
//  rst is synchronous, clears velocities, still count, out_valid and the
//  sequencer, and loads the config registers with their reset values. the
//  result sits in an output register, so a stalled out channel only holds
//  the sequencer in its last step; in_ready is low while an item is in work.
`default_nettype none

module velocity_integration_motion_alarm #(
  parameter int SampleWidth   = vim_pkg::SampleWidthDef,
  parameter int VelocityWidth = vim_pkg::VelocityWidthDef
) (
  input  logic                         clk,
  input  logic                         rst,
  // sample input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SampleWidth-1:0] accel_x,
  input  logic signed [SampleWidth-1:0] accel_y,
  input  logic signed [SampleWidth-1:0] accel_z,
  input  logic [vim_pkg::DtW-1:0]      elapsed_ms,
  // result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         motion_alarm,
  output logic                         rest_reset,
  // register writes
  input  logic                         cfg_we,
  input  logic [vim_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [vim_pkg::CfgDataW-1:0] cfg_data
);

  import vim_pkg::*;

  // deviations carry one extra bit so they never wrap
  localparam int DevW  = SampleWidth + 1;
  localparam int MulA  = (VelocityWidth > DevW) ? VelocityWidth : DevW;
  localparam int MulW  = (MulA > DtW) ? MulA : DtW;
  localparam int ProdW = 2 * MulW;
  localparam int AddW  = ProdW + 2;
  localparam int SumW  = 2 * VelocityWidth;
  localparam int CmpW  = (SumW > ThreshW) ? SumW : ThreshW;
  localparam int DbW   = (DevW > DeadbandW) ? DevW : DeadbandW;

  // configuration registers
  logic signed [SampleWidth-1:0] rest_x, rest_y, rest_z;
  logic [DeadbandW-1:0]          deadband;
  logic [LimitW-1:0]             still_limit;
  logic [ThreshW-1:0]            speed_threshold_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_x             <= SampleWidth'(RestXReset);
      rest_y             <= SampleWidth'(RestYReset);
      rest_z             <= SampleWidth'(RestZReset);
      deadband           <= DeadbandReset;
      still_limit        <= LimitReset;
      speed_threshold_sq <= ThreshReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRestX:    rest_x             <= cfg_data[SampleWidth-1:0];
        RegRestY:    rest_y             <= cfg_data[SampleWidth-1:0];
        RegRestZ:    rest_z             <= cfg_data[SampleWidth-1:0];
        RegDeadband: deadband           <= cfg_data[DeadbandW-1:0];
        RegLimit:    still_limit        <= cfg_data[LimitW-1:0];
        RegThresh:   speed_threshold_sq <= cfg_data[ThreshW-1:0];
        default:     ; // unmapped index, write dropped
      endcase
    end
  end

  // sequencer
  ctrl_t ctrl;
  stat_t stat;
  logic  load;

  vim_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign in_ready = ctrl.in_ready;
  assign load     = in_valid & ctrl.in_ready;

  // deviation from rest, full precision
  logic signed [DevW-1:0] dev_in [3];
  logic [2:0]             moving_in;

  function automatic logic signed [DevW-1:0] deviation(
    input logic signed [SampleWidth-1:0] s,
    input logic signed [SampleWidth-1:0] r
  );
    return $signed({s[SampleWidth-1], s}) - $signed({r[SampleWidth-1], r});
  endfunction

  function automatic logic [DevW-1:0] dev_mag(input logic signed [DevW-1:0] d);
    return d[DevW-1] ? DevW'(-d) : d;
  endfunction

  assign dev_in[0] = deviation(accel_x, rest_x);
  assign dev_in[1] = deviation(accel_y, rest_y);
  assign dev_in[2] = deviation(accel_z, rest_z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      moving_in[i] = DbW'(dev_mag(dev_in[i])) > DbW'(deadband);
    end
  end

  // item registers, captured on acceptance
  logic signed [DevW-1:0] dev [3];
  logic [2:0]             moving;
  logic [DtW-1:0]         dt;

  always_ff @(posedge clk) begin
    if (load) begin
      dev[0] <= dev_in[0];
      dev[1] <= dev_in[1];
      dev[2] <= dev_in[2];
      moving <= moving_in;
      dt     <= elapsed_ms;
    end
  end

  // integration state
  logic signed [VelocityWidth-1:0] vel [3];
  logic [LimitW-1:0]               still_count;
  logic                            zeroed;

  logic signed [DevW-1:0]          dev_sel;
  logic signed [VelocityWidth-1:0] vel_sel;
  logic [VelocityWidth-1:0]        vel_mag;

  assign dev_sel = dev[ctrl.axis];
  assign vel_sel = vel[ctrl.axis];
  assign vel_mag = vel_sel[VelocityWidth-1] ? VelocityWidth'(-vel_sel) : vel_sel;

  // shared multiplier: |deviation| * dt while integrating, |velocity|^2 after
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] prod;
  logic             prod_neg;

  always_comb begin
    if (ctrl.mul_sq) begin
      mul_a = MulW'(vel_mag);
      mul_b = MulW'(vel_mag);
    end else begin
      mul_a = MulW'(dev_mag(dev_sel));
      mul_b = MulW'(dt);
    end
  end

  vim_mul #(
    .Width (MulW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (ctrl.mul_int) begin
      prod_neg <= dev_sel[DevW-1];
    end
  end

  // saturating velocity update
  localparam logic signed [AddW-1:0] VelHi =
    $signed({{(AddW-VelocityWidth+1){1'b0}}, {(VelocityWidth-1){1'b1}}});
  localparam logic signed [AddW-1:0] VelLo =
    $signed({{(AddW-VelocityWidth+1){1'b1}}, {(VelocityWidth-1){1'b0}}});

  logic signed [AddW-1:0]          inc, vel_ext, vel_sum;
  logic signed [VelocityWidth-1:0] vel_sat;

  always_comb begin
    inc     = prod_neg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
    vel_ext = {{(AddW-VelocityWidth){vel_sel[VelocityWidth-1]}}, vel_sel};
    vel_sum = vel_ext + inc;
    if (vel_sum > VelHi) begin
      vel_sat = VelHi[VelocityWidth-1:0];
    end else if (vel_sum < VelLo) begin
      vel_sat = VelLo[VelocityWidth-1:0];
    end else begin
      vel_sat = vel_sum[VelocityWidth-1:0];
    end
  end

  // still counting is done in one extra bit so the count never wraps
  logic [LimitW:0] count_inc;
  logic            limit_hit;

  assign count_inc = {1'b0, still_count} + (LimitW+1)'(1);
  assign limit_hit = count_inc > {1'b0, still_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      vel[0]      <= '0;
      vel[1]      <= '0;
      vel[2]      <= '0;
      still_count <= '0;
      zeroed      <= 1'b0;
    end else if (ctrl.eval) begin
      if (moving == 3'b000) begin
        if (limit_hit) begin
          still_count <= '0;
          vel[0]      <= '0;
          vel[1]      <= '0;
          vel[2]      <= '0;
          zeroed      <= 1'b1;
        end else begin
          still_count <= count_inc[LimitW-1:0];
          zeroed      <= 1'b0;
        end
      end else begin
        still_count <= '0;
        zeroed      <= 1'b0;
      end
    end else if (ctrl.add_int && moving[ctrl.axis]) begin
      vel[ctrl.axis] <= vel_sat;
    end
  end

  // squared speed, accumulated one axis behind the multiplier
  logic [SumW-1:0] sum;

  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      sum <= '0;
    end else if (ctrl.acc_sq) begin
      sum <= sum + prod[SumW-1:0];
    end
  end

  assign stat.in_valid  = in_valid;
  assign stat.all_still = (moving == 3'b000);
  assign stat.out_free  = ~out_valid | out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      motion_alarm <= CmpW'(sum) > CmpW'(speed_threshold_sq);
      rest_reset   <= zeroed;
    end
  end

endmodule

`default_nettype wire
